>>> rtl/bfc_pkg.sv
// Shared types, constants and functions of the bus frame checker.
package bfc_pkg;

	localparam int MAX_CHUNK_DEF = 256;
	localparam int MIN_CHUNK = 7;
	localparam int NUM_HEADERS = 11;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY_RESET = 16'h1021;
	localparam logic [3:0] KIND_UNKNOWN = 4'd11;

	localparam logic [31:0] KNOWN_HEADERS [NUM_HEADERS] = '{
		32'hBBCEE11C, 32'hD0D0D0D0, 32'h55AAADBA, 32'h1CEB00DA,
		32'hBEBAADAB, 32'h0DF005B1, 32'hB5006BB1, 32'h35B1000B,
		32'hCAFEBABE, 32'hCAFED00D, 32'hDABAD000
	};

	typedef enum logic [1:0] {
		VERD_SHORT,
		VERD_MISMATCH,
		VERD_ACCEPTED,
		VERD_OVERLONG
	} verdict_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       chunk_end;
	} item_t;

	typedef struct packed {
		verdict_t    verdict;
		logic [3:0]  message_kind;
		logic [7:0]  node_id;
		logic [7:0]  mode_byte;
		logic [15:0] received_check;
		logic [15:0] computed_check;
		logic [8:0]  chunk_length;
	} result_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] rem, input logic [7:0] b,
			input logic [15:0] poly);
		logic [15:0] r;
		r = rem ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (r[15]) begin
				r = {r[14:0], 1'b0} ^ poly;
			end else begin
				r = {r[14:0], 1'b0};
			end
		end
		return r;
	endfunction

	function automatic logic [3:0] match_kind(input logic [31:0] hdr);
		logic [3:0] kind;
		kind = KIND_UNKNOWN;
		for (int i = NUM_HEADERS - 1; i >= 0; i--) begin
			if (KNOWN_HEADERS[i] == hdr) begin
				kind = 4'(i);
			end
		end
		return kind;
	endfunction

endpackage

>>> rtl/bfc_in_stage.sv
// Input register stage of the bus frame checker.
module bfc_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  bfc_pkg::item_t in_item,
	input  logic           out_can_load,
	output logic           fire_s1,
	output bfc_pkg::item_t item_s1
);
	import bfc_pkg::*;

	logic valid_s1;

	// A byte that ends a chunk moves on only when the result register can take it.
	assign fire_s1 = valid_s1 && (!item_s1.chunk_end || out_can_load);
	assign in_ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

>>> rtl/bfc_chunk_core.sv
// Per-chunk state, CRC update and verdict logic of the bus frame checker.
module bfc_chunk_core #(
	parameter int MAX_CHUNK = bfc_pkg::MAX_CHUNK_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [15:0]      crc_poly,
	input  logic             fire_s1,
	input  bfc_pkg::item_t   item_s1,
	output logic             res_valid,
	output bfc_pkg::result_t res
);
	import bfc_pkg::*;

	localparam int CW = $clog2(MAX_CHUNK + 1);

	logic [CW-1:0] count_q, count_n;
	logic [31:0]   header_q, header_n;
	logic [15:0]   crc_q, crc_n;
	logic [15:0]   held_q, held_n;
	logic [7:0]    id_q, id_n;
	logic [7:0]    mode_q, mode_n;
	logic          overlong_q, overlong_n;
	logic [CW+8:0] len_ext;

	always_comb begin
		overlong_n = overlong_q || (count_q >= CW'(MAX_CHUNK));
		count_n = count_q;
		header_n = header_q;
		crc_n = crc_q;
		held_n = held_q;
		id_n = id_q;
		mode_n = mode_q;
		if (!overlong_n) begin
			if (count_q < CW'(4)) begin
				header_n = {header_q[23:0], item_s1.rx_byte};
			end else if (count_q == CW'(4)) begin
				id_n = item_s1.rx_byte;
			end else if (count_q == CW'(5)) begin
				mode_n = item_s1.rx_byte;
			end
			if (count_q >= CW'(6)) begin
				crc_n = crc_feed(crc_q, held_q[15:8], crc_poly);
			end
			held_n = {held_q[7:0], item_s1.rx_byte};
			count_n = CW'(count_q + 1'b1);
		end
	end

	always_comb begin
		len_ext = (CW + 9)'(count_n);
		res.node_id = id_n;
		res.mode_byte = mode_n;
		res.chunk_length = len_ext[8:0];
		res.received_check = '0;
		res.computed_check = '0;
		res.message_kind = KIND_UNKNOWN;
		if (overlong_n) begin
			res.verdict = VERD_OVERLONG;
		end else if (count_n < CW'(MIN_CHUNK)) begin
			res.verdict = VERD_SHORT;
		end else begin
			res.received_check = {held_n[7:0], held_n[15:8]};
			res.computed_check = {crc_n[7:0], crc_n[15:8]};
			res.verdict = (res.received_check == res.computed_check) ?
				VERD_ACCEPTED : VERD_MISMATCH;
			res.message_kind = match_kind(header_n);
		end
	end

	assign res_valid = fire_s1 && item_s1.chunk_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			header_q <= '0;
			crc_q <= CRC_INIT;
			held_q <= '0;
			id_q <= '0;
			mode_q <= '0;
			overlong_q <= 1'b0;
		end else if (res_valid) begin
			count_q <= '0;
			header_q <= '0;
			crc_q <= CRC_INIT;
			held_q <= '0;
			id_q <= '0;
			mode_q <= '0;
			overlong_q <= 1'b0;
		end else if (fire_s1) begin
			count_q <= count_n;
			header_q <= header_n;
			crc_q <= crc_n;
			held_q <= held_n;
			id_q <= id_n;
			mode_q <= mode_n;
			overlong_q <= overlong_n;
		end
	end

endmodule

>>> rtl/bfc_out_stage.sv
// Result register of the bus frame checker.
module bfc_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             res_valid,
	input  bfc_pkg::result_t res,
	output logic             can_load,
	output logic             out_valid,
	input  logic             out_ready,
	output bfc_pkg::result_t res_q
);
	import bfc_pkg::*;

	assign can_load = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (res_valid) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

endmodule

>>> rtl/bus_frame_checker.sv
// Top level of the bus frame checker.
// The checker takes one received byte per cycle and gives one result transaction at the end of
// each chunk, once its last byte has passed the input register and then the result register.
// Header capture, the byte-wide CRC-16 step and the header compare all sit in the logic between
// those two registers. Input stalls only when a chunk's last byte is held while the previous
// result has not yet been taken. The CRC polynomial should be written only between chunks.
module bus_frame_checker #(
	parameter int MAX_CHUNK = bfc_pkg::MAX_CHUNK_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        crc_polynomial_we,
	input  logic [15:0] crc_polynomial_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // rx_byte
	input  logic        s_tlast,   // chunk_end
	output logic        m_tvalid,
	input  logic        m_tready,
	// verdict[1:0], node_id[9:2], mode_byte[17:10], received_check[33:18],
	// computed_check[49:34], chunk_length[58:50], zero fill[63:59]
	output logic [63:0] m_tdata,
	output logic [3:0]  m_tuser    // message_kind
);
	import bfc_pkg::*;

	logic [15:0] crc_poly_q;
	item_t       in_item;
	item_t       item_s1;
	logic        fire_s1;
	logic        out_can_load;
	logic        res_valid;
	result_t     res;
	result_t     res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_poly_q <= CRC_POLY_RESET;
		end else if (crc_polynomial_we) begin
			crc_poly_q <= crc_polynomial_wdata;
		end
	end

	assign in_item.rx_byte = s_tdata;
	assign in_item.chunk_end = s_tlast;

	bfc_in_stage u_in_stage (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_item      (in_item),
		.out_can_load (out_can_load),
		.fire_s1      (fire_s1),
		.item_s1      (item_s1)
	);

	bfc_chunk_core #(
		.MAX_CHUNK (MAX_CHUNK)
	) u_chunk_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.crc_poly  (crc_poly_q),
		.fire_s1   (fire_s1),
		.item_s1   (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	bfc_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.can_load  (out_can_load),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.res_q     (res_q)
	);

	assign m_tdata = {5'b0, res_q.chunk_length, res_q.computed_check, res_q.received_check,
		res_q.mode_byte, res_q.node_id, res_q.verdict};
	assign m_tuser = res_q.message_kind;

	// Short and overlong chunks never report a matched header.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (res_q.verdict == VERD_SHORT || res_q.verdict == VERD_OVERLONG)
		|-> m_tuser == KIND_UNKNOWN)
		else $error("short or overlong chunk reported a header match");

	// An accepted chunk carries equal received and computed checks.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_q.verdict == VERD_ACCEPTED
		|-> res_q.received_check == res_q.computed_check)
		else $error("accepted verdict with unequal checks");

	// An overlong chunk reports the saturated length.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_q.verdict == VERD_OVERLONG |-> res_q.chunk_length == 9'(MAX_CHUNK))
		else $error("overlong chunk without saturated length");

	// Input back-pressure only comes from a stalled result.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled while the result register was free");

endmodule

>>> tb/tb_bus_frame_checker.sv
// Self-checking bench for the bus frame checker: directed, CRC, length, back-pressure and random chunks.
`timescale 1ns / 1ps

module tb_bus_frame_checker;
	import bfc_pkg::*;

	localparam int MAX_LEN = MAX_CHUNK_DEF;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SHOWN_FAULTS = 10;
	localparam int ITEM_TARGET = 750;

	typedef logic [7:0] byte_queue_t[$];

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        crc_polynomial_we;
	logic [15:0] crc_polynomial_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic [3:0]  m_tuser;

	// Mirror of the checker state, kept per chunk.
	logic [15:0] poly_now;
	int          seen_bytes;
	logic [31:0] hdr_word;
	logic [15:0] crc_acc;
	logic [15:0] tail_pair;
	logic [7:0]  node_byte;
	logic [7:0]  mode_field;
	bit          dropped;

	result_t expected_reports[$];
	int      fault_count = 0;
	int      bytes_sent = 0;
	int      stall_cycles = 0;
	bit      tx_idle_en = 1'b1;
	bit      rx_idle_en = 1'b1;
	int      rx_long_hold = 0;

	bus_frame_checker dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.crc_polynomial_we    (crc_polynomial_we),
		.crc_polynomial_wdata (crc_polynomial_wdata),
		.s_tvalid             (s_tvalid),
		.s_tready             (s_tready),
		.s_tdata              (s_tdata),
		.s_tlast              (s_tlast),
		.m_tvalid             (m_tvalid),
		.m_tready             (m_tready),
		.m_tdata              (m_tdata),
		.m_tuser              (m_tuser)
	);

	always #6 clk = ~clk;

	function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] data,
			input logic [15:0] poly);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb = acc[15] ^ data[i];
			acc = {acc[14:0], 1'b0};
			if (fb) begin
				acc = acc ^ poly;
			end
		end
		return acc;
	endfunction

	function automatic logic [3:0] header_index(input logic [31:0] hdr);
		for (int i = 0; i < NUM_HEADERS; i++) begin
			if (KNOWN_HEADERS[i] == hdr) begin
				return 4'(i);
			end
		end
		return KIND_UNKNOWN;
	endfunction

	function automatic void clear_chunk_state();
		seen_bytes = 0;
		hdr_word = '0;
		crc_acc = CRC_INIT;
		tail_pair = '0;
		node_byte = '0;
		mode_field = '0;
		dropped = 1'b0;
	endfunction

	function automatic void predict_byte(input logic [7:0] b, input logic last);
		result_t r;
		if (!dropped && seen_bytes >= MAX_LEN) begin
			dropped = 1'b1;
		end
		if (!dropped) begin
			if (seen_bytes < 4) begin
				hdr_word = {hdr_word[23:0], b};
			end else if (seen_bytes == 4) begin
				node_byte = b;
			end else if (seen_bytes == 5) begin
				mode_field = b;
			end
			if (seen_bytes >= 6) begin
				crc_acc = crc16_step(crc_acc, tail_pair[15:8], poly_now);
			end
			tail_pair = {tail_pair[7:0], b};
			seen_bytes++;
		end
		if (last) begin
			r = '0;
			r.node_id = node_byte;
			r.mode_byte = mode_field;
			r.chunk_length = 9'(seen_bytes);
			r.message_kind = KIND_UNKNOWN;
			if (dropped) begin
				r.verdict = VERD_OVERLONG;
			end else if (seen_bytes < MIN_CHUNK) begin
				r.verdict = VERD_SHORT;
			end else begin
				r.received_check = {tail_pair[7:0], tail_pair[15:8]};
				r.computed_check = {crc_acc[7:0], crc_acc[15:8]};
				r.verdict = (r.received_check == r.computed_check) ? VERD_ACCEPTED : VERD_MISMATCH;
				r.message_kind = header_index(hdr_word);
			end
			expected_reports = {expected_reports, r};
			clear_chunk_state();
		end
	endfunction

	function automatic string fmt_report(input result_t r);
		return $sformatf("verdict=%0d kind=%0d node=%02h mode=%02h rcv=%04h cmp=%04h len=%0d",
			r.verdict, r.message_kind, r.node_id, r.mode_byte, r.received_check,
			r.computed_check, r.chunk_length);
	endfunction

	function automatic void log_fault(input string what, input result_t want, input result_t got);
		fault_count++;
		if (fault_count <= SHOWN_FAULTS) begin
			$display("[%0t] %s", $realtime, what);
			$display("    expected: %s", fmt_report(want));
			$display("    actual:   %s", fmt_report(got));
		end
	endfunction

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.verdict = verdict_t'(m_tdata[1:0]);
			got.node_id = m_tdata[9:2];
			got.mode_byte = m_tdata[17:10];
			got.received_check = m_tdata[33:18];
			got.computed_check = m_tdata[49:34];
			got.chunk_length = m_tdata[58:50];
			got.message_kind = m_tuser;
			if (expected_reports.size() == 0) begin
				log_fault("result transaction with nothing expected", '0, got);
			end else begin
				want = expected_reports.pop_front();
				if (got.verdict !== want.verdict || got.message_kind !== want.message_kind ||
						got.node_id !== want.node_id || got.mode_byte !== want.mode_byte ||
						got.received_check !== want.received_check ||
						got.computed_check !== want.computed_check ||
						got.chunk_length !== want.chunk_length || m_tdata[63:59] !== 5'd0) begin
					log_fault("result mismatch", want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin : result_sink
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = rx_idle_en ? $urandom_range(0, 14) : 0;
			if (rx_long_hold > 0) begin
				gap = rx_long_hold;
				rx_long_hold = 0;
			end
			@(negedge clk);
			repeat (gap) begin
				m_tready <= 1'b0;
				@(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = tx_idle_en ? $urandom_range(0, 14) : 0;
		@(negedge clk);
		repeat (gap) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'($urandom);
			s_tlast <= 1'($urandom);
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		predict_byte(b, last);
		bytes_sent++;
	endtask

	task automatic send_chunk(input byte_queue_t q);
		foreach (q[i]) begin
			send_byte(q[i], i == q.size() - 1);
		end
	endtask

	task automatic send_random_chunk(input int len);
		byte_queue_t q;
		repeat (len) q = {q, 8'($urandom)};
		send_chunk(q);
	endtask

	// Header, body, then the CRC over the body high byte first so that the check matches.
	task automatic send_frame(input logic [31:0] hdr, input int body_len, input bit corrupt);
		byte_queue_t q;
		logic [15:0] acc;
		logic [7:0]  b;
		int          idx;
		acc = CRC_INIT;
		for (int i = 3; i >= 0; i--) begin
			q = {q, hdr[8*i +: 8]};
		end
		repeat (body_len) begin
			b = 8'($urandom);
			q = {q, b};
			acc = crc16_step(acc, b, poly_now);
		end
		q = {q, acc[15:8]};
		q = {q, acc[7:0]};
		if (corrupt) begin
			idx = $urandom_range(4, q.size() - 1);
			q[idx] = q[idx] ^ (8'd1 << $urandom_range(0, 7));
		end
		send_chunk(q);
	endtask

	function automatic logic [31:0] pick_header();
		logic [31:0] hdr;
		int          roll;
		roll = $urandom_range(0, 19);
		hdr = KNOWN_HEADERS[$urandom_range(0, NUM_HEADERS - 1)];
		if (roll < 2) begin
			hdr = hdr ^ (32'd1 << $urandom_range(0, 31));
		end else if (roll < 5) begin
			hdr = $urandom;
		end
		return hdr;
	endfunction

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_reports.size() != 0) @(posedge clk);
	endtask

	task automatic set_crc_poly(input logic [15:0] value);
		drain();
		repeat (4) @(negedge clk);
		crc_polynomial_we <= 1'b1;
		crc_polynomial_wdata <= value;
		@(negedge clk);
		crc_polynomial_we <= 1'b0;
		poly_now = value;
	endtask

	task automatic test_directed();
		byte_queue_t q;
		q = '{8'hFF};
		send_chunk(q);
		q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
		send_chunk(q);
		send_frame(KNOWN_HEADERS[NUM_HEADERS - 1], 1, 1'b0);
		send_frame(KNOWN_HEADERS[0], 1, 1'b1);
		drain();
	endtask

	task automatic test_crc_polynomials();
		logic [15:0] polys[] = '{16'h0000, 16'hFFFF, 16'h8005, 16'h8408, 16'h0001, 16'h8000,
			CRC_POLY_RESET};
		foreach (polys[i]) begin
			set_crc_poly(polys[i]);
			send_frame(pick_header(), $urandom_range(1, 10), 1'b0);
			send_frame(pick_header(), $urandom_range(1, 10), 1'b1);
		end
		drain();
	endtask

	task automatic test_length_limits();
		tx_idle_en = 1'b0;
		send_frame(KNOWN_HEADERS[3], MAX_LEN - 5, 1'b0);
		send_frame(KNOWN_HEADERS[5], 4, 1'b0);
		tx_idle_en = 1'b1;
		drain();
	endtask

	task automatic test_backpressure();
		tx_idle_en = 1'b0;
		rx_long_hold = 300;
		repeat (6) send_frame(pick_header(), $urandom_range(1, 4), 1'b0);
		tx_idle_en = 1'b1;
		drain();
	endtask

	task automatic test_random_traffic();
		int chunks;
		chunks = 0;
		while (bytes_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 19) == 0) begin
				tx_idle_en = 1'($urandom);
				rx_idle_en = 1'($urandom);
			end
			if (chunks % 8 == 7) begin
				set_crc_poly(16'($urandom));
			end
			case ($urandom_range(0, 9))
				0: begin
					send_random_chunk($urandom_range(1, MIN_CHUNK - 1));
				end
				1: begin
					send_random_chunk($urandom_range(MIN_CHUNK, 20));
				end
				2: begin
					send_frame(pick_header(), $urandom_range(1, 14), 1'b1);
				end
				default: begin
					send_frame(pick_header(), $urandom_range(1, 14), 1'b0);
				end
			endcase
			chunks++;
		end
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		drain();
	endtask

	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		crc_polynomial_we = 1'b0;
		crc_polynomial_wdata = '0;
		poly_now = CRC_POLY_RESET;
		clear_chunk_state();
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_crc_polynomials();
		test_length_limits();
		test_backpressure();
		test_random_traffic();

		drain();
		repeat (8) @(posedge clk);
		fault_count += expected_reports.size();
		if (fault_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
